// ===== rtl/brv_pkg.sv =====
// shared types and constants for the batch running variance unit
package brv_pkg;

	typedef struct packed {
		logic signed [31:0] sample_value;
		logic [2:0]         dim_index;
		logic               end_of_batch;
	} sample_t;

	typedef struct packed {
		logic [2:0]         out_dim;
		logic signed [31:0] mean_value;
		logic [47:0]        variance_value;
		logic               single_point;
		logic               last_of_run;
	} result_t;

	localparam logic [3:0]  DIMS_RESET = 4'd8;
	localparam logic [47:0] VAR_ONE    = 48'h0000_0001_0000;
	localparam int          DIV_W      = 128;
	localparam int          DEN_W      = 34;

	typedef enum logic [4:0] {
		ST_IDLE, ST_LOAD, ST_MUL_T, ST_TOT, ST_DIV_M, ST_MEAN,
		ST_MUL_V0, ST_MUL_V1, ST_MUL_MM, ST_WAIT_SQ, ST_MUL_S0, ST_MUL_S1,
		ST_MUL_NN, ST_WAIT_NN, ST_MUL_R0, ST_MUL_R1, ST_WAIT_R, ST_CMP,
		ST_DIV_V, ST_VAR, ST_OUT, ST_FIN
	} st_t;

	typedef enum logic [2:0] {
		OP_NONE, OP_ACCUM, OP_LOAD, OP_TOT, OP_MEAN, OP_CMP, OP_VAR, OP_FIN
	} op_t;

	typedef enum logic [3:0] {
		MUL_NONE, MUL_T, MUL_V0, MUL_V1, MUL_MM, MUL_S0, MUL_S1, MUL_NN,
		MUL_R0, MUL_R1
	} mul_t;

	typedef struct packed {
		op_t        op;
		mul_t       mul;
		logic [2:0] k;
	} cmd_t;

	typedef struct packed {
		logic nn_zero;
		logic nn_one;
		logic pos_le_neg;
		logic div_busy;
	} status_t;

endpackage

// ===== rtl/brv_div.sv =====
// restoring divider, one quotient bit per cycle
module brv_div import brv_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             busy,
	output logic [DIV_W-1:0] quotient
);
	localparam int CW = $clog2(DIV_W);

	logic [DIV_W-1:0] dq_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   rem_sh;
	logic             ge;
	logic [DEN_W:0]   rem_nx;

	assign rem_sh = {rem_q, dq_q[DIV_W-1]};
	assign ge     = rem_sh >= {1'b0, den_q};
	assign rem_nx = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(DIV_W - 1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			dq_q  <= {dq_q[DIV_W-2:0], ge};
			rem_q <= rem_nx[DEN_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = dq_q;
endmodule

// ===== rtl/brv_dp.sv =====
// datapath: per-dimension stores, accumulation, merge arithmetic
module brv_dp import brv_pkg::*; #(
	parameter int DEPTH = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	input  sample_t    sample_data,
	input  logic [3:0] dact,
	output status_t    status,
	output result_t    result_data
);
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [31:0] mean_q [DEPTH];
	logic [47:0] var_q  [DEPTH];
	logic [47:0] sum_q  [DEPTH];
	logic [63:0] sqs_q  [DEPTH];
	logic [31:0] total_q, batch_q;

	logic [31:0]  mmag_q, nmag_q;
	logic         mneg_q, sneg_q, tneg_q;
	logic [47:0]  smag_q, varw_q;
	logic [63:0]  sq_q;
	logic [127:0] pos_q, neg_q;
	logic [64:0]  prod_s1;
	mul_t         pmul_s1;

	logic [32:0] nn, nn_m1;
	logic [31:0] nm1;
	logic [IW-1:0] ra, ki;
	logic [47:0] rd_sum;
	logic [63:0] rd_sqs;
	logic [31:0] smp, smag_in, mraw;
	logic [63:0] sqfull;
	logic [64:0] sqs_add;
	logic        in_range, is_last_dim;
	logic [31:0] mul_a;
	logic [32:0] mul_b;
	logic [63:0] tmag, tot;
	logic        tneg;
	logic        div_start, div_busy;
	logic [127:0] div_dvd, div_q;
	logic [33:0] div_den;
	logic [31:0] qsat;

	assign nn    = {1'b0, total_q} + {1'b0, batch_q};
	assign nn_m1 = nn - 33'd1;
	assign nm1   = (total_q == '0) ? '0 : (total_q - 32'd1);
	assign ki    = cmd.k[IW-1:0];
	assign ra    = (cmd.op == OP_ACCUM) ? sample_data.dim_index[IW-1:0] : ki;
	assign rd_sum = sum_q[ra];
	assign rd_sqs = sqs_q[ra];

	assign smp      = sample_data.sample_value;
	assign smag_in  = smp[31] ? (~smp + 32'd1) : smp;
	assign sqfull   = smag_in * smag_in;
	assign sqs_add  = {1'b0, rd_sqs} + {17'b0, sqfull[63:16]};
	assign in_range = {1'b0, sample_data.dim_index} < dact;
	assign is_last_dim = {1'b0, sample_data.dim_index} == (dact - 4'd1);
	assign mraw     = mean_q[ki];

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul)
			MUL_T:  begin mul_a = mmag_q;            mul_b = {1'b0, total_q}; end
			MUL_V0: begin mul_a = varw_q[31:0];      mul_b = {1'b0, nm1}; end
			MUL_V1: begin mul_a = {16'b0, varw_q[47:32]}; mul_b = {1'b0, nm1}; end
			MUL_MM: begin mul_a = mmag_q;            mul_b = {1'b0, mmag_q}; end
			MUL_S0: begin mul_a = sq_q[31:0];        mul_b = {1'b0, total_q}; end
			MUL_S1: begin mul_a = sq_q[63:32];       mul_b = {1'b0, total_q}; end
			MUL_NN: begin mul_a = nmag_q;            mul_b = {1'b0, nmag_q}; end
			MUL_R0: begin mul_a = sq_q[31:0];        mul_b = nn; end
			MUL_R1: begin mul_a = sq_q[63:32];       mul_b = nn; end
			default: begin mul_a = '0;               mul_b = '0; end
		endcase
	end

	// signed sum of n*mean and batch sum
	assign tmag = prod_s1[63:0];
	always_comb begin
		if (mneg_q == sneg_q) begin
			tot  = tmag + {16'b0, smag_q};
			tneg = mneg_q;
		end else if (tmag >= {16'b0, smag_q}) begin
			tot  = tmag - {16'b0, smag_q};
			tneg = mneg_q;
		end else begin
			tot  = {16'b0, smag_q} - tmag;
			tneg = sneg_q;
		end
	end

	assign div_start = (cmd.op == OP_TOT) || ((cmd.op == OP_CMP) && !(pos_q <= neg_q));
	assign div_dvd   = (cmd.op == OP_TOT) ? {64'b0, tot} : (pos_q - neg_q);
	assign div_den   = (cmd.op == OP_TOT) ? {1'b0, nn} : {1'b0, nn_m1};

	brv_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_den),
		.busy     (div_busy),
		.quotient (div_q)
	);

	always_comb begin
		if (tneg_q) qsat = (div_q > 128'h8000_0000) ? 32'h8000_0000 : div_q[31:0];
		else        qsat = (div_q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_q[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pmul_s1 <= MUL_NONE;
		end else begin
			pmul_s1 <= cmd.mul;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		case (pmul_s1)
			MUL_V0: pos_q <= pos_q + {47'b0, prod_s1, 16'b0};
			MUL_V1: pos_q <= pos_q + {15'b0, prod_s1, 48'b0};
			MUL_MM: sq_q  <= prod_s1[63:0];
			MUL_S0: pos_q <= pos_q + {63'b0, prod_s1};
			MUL_S1: pos_q <= pos_q + {31'b0, prod_s1, 32'b0};
			MUL_NN: sq_q  <= prod_s1[63:0];
			MUL_R0: neg_q <= {63'b0, prod_s1};
			MUL_R1: neg_q <= neg_q + {31'b0, prod_s1, 32'b0};
			default: ;
		endcase
		case (cmd.op)
			OP_LOAD: begin
				mneg_q <= mraw[31];
				mmag_q <= mraw[31] ? (~mraw + 32'd1) : mraw;
				sneg_q <= rd_sum[47];
				smag_q <= rd_sum[47] ? (~rd_sum + 48'd1) : rd_sum;
				varw_q <= var_q[ki];
				pos_q  <= {48'b0, rd_sqs, 16'b0};
			end
			OP_TOT:  tneg_q <= tneg;
			OP_MEAN: nmag_q <= qsat;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				mean_q[i] <= '0;
				var_q[i]  <= '0;
				sum_q[i]  <= '0;
				sqs_q[i]  <= '0;
			end
			total_q <= '0;
			batch_q <= '0;
		end else begin
			case (cmd.op)
				OP_ACCUM: begin
					if (in_range) begin
						sum_q[ra] <= rd_sum + {{16{smp[31]}}, smp};
						sqs_q[ra] <= sqs_add[64] ? '1 : sqs_add[63:0];
						if (is_last_dim && batch_q != '1) batch_q <= batch_q + 32'd1;
					end
				end
				OP_MEAN: begin
					mean_q[ki] <= tneg_q ? (~qsat + 32'd1) : qsat;
					if (nn == 33'd1) var_q[ki] <= VAR_ONE;
				end
				OP_CMP: begin
					if (pos_q <= neg_q) var_q[ki] <= '0;
				end
				OP_VAR: begin
					var_q[ki] <= (div_q[127:64] != '0) ? '1 : div_q[63:16];
				end
				OP_FIN: begin
					for (int i = 0; i < DEPTH; i++) begin
						sum_q[i] <= '0;
						sqs_q[i] <= '0;
					end
					total_q <= nn[32] ? '1 : nn[31:0];
					batch_q <= '0;
				end
				default: ;
			endcase
		end
	end

	assign status.nn_zero    = (nn == '0);
	assign status.nn_one     = (nn == 33'd1);
	assign status.pos_le_neg = (pos_q <= neg_q);
	assign status.div_busy   = div_busy;

	assign result_data.out_dim        = cmd.k;
	assign result_data.mean_value     = mean_q[ki];
	assign result_data.variance_value = var_q[ki];
	assign result_data.single_point   = (nn == 33'd1);
	assign result_data.last_of_run    = ({1'b0, cmd.k} == (dact - 4'd1));
endmodule

// ===== rtl/brv_ctrl.sv =====
// controller: sample intake, per-dimension merge sequence, result handshake
module brv_ctrl import brv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       sample_valid,
	input  logic       sample_eob,
	input  logic       result_stall,
	input  logic [3:0] dact,
	input  status_t    status,
	output cmd_t       cmd,
	output logic       sample_stall,
	output logic       result_valid
);
	st_t        state_q, state_nx;
	logic [2:0] k_q;
	logic       last_k;

	assign last_k = ({1'b0, k_q} == (dact - 4'd1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_IDLE) k_q <= '0;
			else if (state_q == ST_OUT && !result_stall && !last_k) k_q <= k_q + 3'd1;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd.op   = OP_NONE;
		cmd.mul  = MUL_NONE;
		cmd.k    = k_q;
		unique case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					cmd.op = OP_ACCUM;
					if (sample_eob) state_nx = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.op   = OP_LOAD;
				state_nx = status.nn_zero ? ST_OUT : ST_MUL_T;
			end
			ST_MUL_T:  begin cmd.mul = MUL_T; state_nx = ST_TOT; end
			ST_TOT:    begin cmd.op = OP_TOT; state_nx = ST_DIV_M; end
			ST_DIV_M:  if (!status.div_busy) state_nx = ST_MEAN;
			ST_MEAN: begin
				cmd.op   = OP_MEAN;
				state_nx = status.nn_one ? ST_OUT : ST_MUL_V0;
			end
			ST_MUL_V0:  begin cmd.mul = MUL_V0; state_nx = ST_MUL_V1; end
			ST_MUL_V1:  begin cmd.mul = MUL_V1; state_nx = ST_MUL_MM; end
			ST_MUL_MM:  begin cmd.mul = MUL_MM; state_nx = ST_WAIT_SQ; end
			ST_WAIT_SQ: state_nx = ST_MUL_S0;
			ST_MUL_S0:  begin cmd.mul = MUL_S0; state_nx = ST_MUL_S1; end
			ST_MUL_S1:  begin cmd.mul = MUL_S1; state_nx = ST_MUL_NN; end
			ST_MUL_NN:  begin cmd.mul = MUL_NN; state_nx = ST_WAIT_NN; end
			ST_WAIT_NN: state_nx = ST_MUL_R0;
			ST_MUL_R0:  begin cmd.mul = MUL_R0; state_nx = ST_MUL_R1; end
			ST_MUL_R1:  begin cmd.mul = MUL_R1; state_nx = ST_WAIT_R; end
			ST_WAIT_R:  state_nx = ST_CMP;
			ST_CMP: begin
				cmd.op   = OP_CMP;
				state_nx = status.pos_le_neg ? ST_OUT : ST_DIV_V;
			end
			ST_DIV_V:  if (!status.div_busy) state_nx = ST_VAR;
			ST_VAR:    begin cmd.op = OP_VAR; state_nx = ST_OUT; end
			ST_OUT: begin
				if (!result_stall) state_nx = last_k ? ST_FIN : ST_LOAD;
			end
			ST_FIN:    begin cmd.op = OP_FIN; state_nx = ST_IDLE; end
			default:   state_nx = ST_IDLE;
		endcase
	end

	assign sample_stall = (state_q != ST_IDLE);
	assign result_valid = (state_q == ST_OUT);
endmodule

// ===== rtl/batch_running_variance_unit.sv =====
// top level of the batch running variance unit
// Keeps a running mean and diagonal variance per dimension over batches of
// Q16.16 samples. While no batch merge is in progress a sample transaction is
// taken every cycle; the sample that carries end_of_batch starts a merge, and
// the block then stalls its input until the last result transaction has been
// taken and the merge has closed. Each dimension of the merge costs up to two
// passes of a one-bit-per-cycle 128-bit divider (mean, then variance) plus
// load, shared multiplier steps and output, plus the wait on result_stall.
// With a single point in total the variance pass is skipped; when the variance
// comes out non-positive its divide is skipped; a merge with no points at all
// goes straight from load to output for each dimension, and a closing state
// ends the merge.
// Results come out in dimension order, one per dimension in use.
module batch_running_variance_unit import brv_pkg::*; #(
	parameter int MAX_DIMS = 8
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cfg_wr_en,
	input  logic [3:0] cfg_wr_data,
	input  logic    sample_valid,
	output logic    sample_stall,
	input  sample_t sample_data,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result_data
);
	// storage never exceeds the eight codes of dim_index
	localparam int DEPTH = (MAX_DIMS < 8) ? MAX_DIMS : 8;

	logic [3:0] dims_q;
	logic [3:0] dims_nz;
	logic [3:0] dact;
	cmd_t       cmd;
	status_t    status;

	// dimension count register, zero acts as one, clamped to storage depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= DIMS_RESET;
		end else if (cfg_wr_en) begin
			dims_q <= cfg_wr_data;
		end
	end

	assign dims_nz = (dims_q == '0) ? 4'd1 : dims_q;
	assign dact    = (dims_nz > 4'(DEPTH)) ? 4'(DEPTH) : dims_nz;

	// sequencer for intake and merge
	brv_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_eob   (sample_data.end_of_batch),
		.result_stall (result_stall),
		.dact         (dact),
		.status       (status),
		.cmd          (cmd),
		.sample_stall (sample_stall),
		.result_valid (result_valid)
	);

	// stores and arithmetic
	brv_dp #(.DEPTH(DEPTH)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sample_data (sample_data),
		.dact        (dact),
		.status      (status),
		.result_data (result_data)
	);

`ifndef SYNTH
	// no sample transaction while results are pending
	a_out_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> sample_stall)
		else $error("sample intake open during result output");

	// end of batch starts the merge
	a_eob_merge: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && !sample_stall && sample_data.end_of_batch) |=> sample_stall)
		else $error("merge did not start after end of batch");

	// last result transaction ends the run
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_stall && result_data.last_of_run) |=> !result_valid)
		else $error("result after last of run");
`endif
endmodule

// ===== tb/testbench.sv =====
// testbench for the batch running variance unit: random batches checked against a predictor
`timescale 1ns / 1ps

// expected results of the running mean and variance merge, and their checking
class variance_board;
	logic [31:0] mean_q [8];
	logic [47:0] var_q [8];
	logic [47:0] sum_q [8];
	logic [63:0] sqsum_q [8];
	logic [31:0] total_pts;
	logic [31:0] batch_pts;
	logic [3:0]  dims;
	brv_pkg::result_t expected_q [$];
	int mismatches;

	function new();
		for (int k = 0; k < 8; k++) begin
			mean_q[k] = '0;
			var_q[k] = '0;
			sum_q[k] = '0;
			sqsum_q[k] = '0;
		end
		total_pts = '0;
		batch_pts = '0;
		dims = brv_pkg::DIMS_RESET;
		mismatches = 0;
	endfunction

	// zero counts as one, anything past eight is clamped
	function int active_dims();
		int d;
		d = dims;
		if (d == 0) d = 1;
		if (d > 8) d = 8;
		return d;
	endfunction

	function void merge_dim(int k, logic [63:0] n, logic [63:0] nn);
		logic [63:0]  mmag, smag, tmag, tot, q;
		logic         mneg, sneg, tneg;
		logic [127:0] pos, neg, diff;
		mneg = mean_q[k][31];
		mmag = mneg ? 64'h1_0000_0000 - {32'b0, mean_q[k]} : {32'b0, mean_q[k]};
		sneg = sum_q[k][47];
		smag = sneg ? 64'h1_0000_0000_0000 - {16'b0, sum_q[k]} : {16'b0, sum_q[k]};
		tmag = n * mmag;
		if (mneg == sneg) begin
			tot = tmag + smag;
			tneg = mneg;
		end else if (tmag >= smag) begin
			tot = tmag - smag;
			tneg = mneg;
		end else begin
			tot = smag - tmag;
			tneg = sneg;
		end
		q = tot / nn;
		if (tneg) begin
			if (q > 64'h8000_0000) q = 64'h8000_0000;
			mean_q[k] = 32'(64'h1_0000_0000 - q);
		end else begin
			if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
			mean_q[k] = q[31:0];
		end
		if (nn == 1) begin
			var_q[k] = brv_pkg::VAR_ONE;
			return;
		end
		pos = (128'(var_q[k]) << 16) * 128'((n > 0) ? n - 1 : 64'd0);
		pos = pos + 128'(mmag * mmag) * 128'(n);
		pos = pos + (128'(sqsum_q[k]) << 16);
		neg = 128'(q * q) * 128'(nn);
		if (pos <= neg) begin
			var_q[k] = '0;
			return;
		end
		diff = (pos - neg) / 128'(nn - 1);
		if ((diff >> 16) > 128'hFFFF_FFFF_FFFF) var_q[k] = '1;
		else var_q[k] = diff[63:16];
	endfunction

	function void note_sample(brv_pkg::sample_t s);
		logic [31:0] raw;
		logic [63:0] mag, sq, n, nn;
		int d;
		brv_pkg::result_t r;
		d = active_dims();
		raw = s.sample_value;
		if (int'(s.dim_index) < d) begin
			mag = raw[31] ? 64'h1_0000_0000 - {32'b0, raw} : {32'b0, raw};
			sq = (mag * mag) >> 16;
			sum_q[s.dim_index] = sum_q[s.dim_index] + {{16{raw[31]}}, raw};
			sqsum_q[s.dim_index] = (sqsum_q[s.dim_index] > ~64'd0 - sq) ?
				~64'd0 : sqsum_q[s.dim_index] + sq;
			if (int'(s.dim_index) == d - 1 && batch_pts != '1) batch_pts++;
		end
		if (!s.end_of_batch) return;
		n = {32'b0, total_pts};
		nn = n + {32'b0, batch_pts};
		for (int k = 0; k < d; k++) begin
			if (nn != 0) merge_dim(k, n, nn);
			r.out_dim = 3'(k);
			r.mean_value = mean_q[k];
			r.variance_value = var_q[k];
			r.single_point = (nn == 1);
			r.last_of_run = (k == d - 1);
			expected_q.insert(expected_q.size(), r);
		end
		for (int k = 0; k < 8; k++) begin
			sum_q[k] = '0;
			sqsum_q[k] = '0;
		end
		total_pts = (nn > 64'hFFFF_FFFF) ? '1 : nn[31:0];
		batch_pts = '0;
	endfunction

	function void check_result(brv_pkg::result_t r);
		brv_pkg::result_t e;
		if (expected_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result: dim %0d mean %h var %h",
				r.out_dim, r.mean_value, r.variance_value);
			return;
		end
		e = expected_q.pop_front();
		if (r.out_dim !== e.out_dim || r.mean_value !== e.mean_value ||
			r.variance_value !== e.variance_value || r.single_point !== e.single_point ||
			r.last_of_run !== e.last_of_run) begin
			mismatches++;
			if (mismatches <= 10) $display({
				"mismatch: exp dim %0d mean %h var %h single %b last %b",
				" / got dim %0d mean %h var %h single %b last %b"},
				e.out_dim, e.mean_value, e.variance_value, e.single_point, e.last_of_run,
				r.out_dim, r.mean_value, r.variance_value, r.single_point, r.last_of_run);
		end
	endfunction
endclass

module testbench;
	import brv_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 40;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    cfg_wr_en;
	logic [3:0] cfg_wr_data;
	logic    sample_valid;
	logic    sample_stall;
	sample_t sample_data;
	logic    result_valid;
	logic    result_stall;
	result_t result_data;

	variance_board board = new();
	int  results_seen = 0;
	int  idle_cycles = 0;
	bit  no_idle = 0;   // stretches with no gaps on either side

	batch_running_variance_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_data  (sample_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// monitor: note accepted samples, check accepted results, watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_valid && !sample_stall) board.note_sample(sample_data);
			if (result_valid && !result_stall) begin
				board.check_result(result_data);
				results_seen++;
			end
			if ((sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("testbench: FAIL");
				$finish;
			end
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		if (no_idle) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
		if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
		return 0;
	endfunction

	// receiver side: random stalls plus one long hold-off once results flow
	initial begin
		int hold;
		bit held;
		hold = 0;
		held = 0;
		result_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
				result_stall <= 1'b1;
			end else if (!held && results_seen >= 30) begin
				held = 1;
				hold = 1500;
				result_stall <= 1'b1;
			end else begin
				hold = pick_gap();
				result_stall <= (hold > 0);
			end
		end
	end

	// one sample transaction, then an optional gap
	task automatic send_sample(input logic [31:0] value, input int dim, input bit eob);
		sample_t s;
		int gap;
		s.sample_value = value;
		s.dim_index = 3'(dim);
		s.end_of_batch = eob;
		sample_data <= s;
		sample_valid <= 1'b1;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// wait for every expected result, then let a trailing merge finish
	task automatic drain();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (board.expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_dims(input logic [3:0] value);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		board.dims = value;
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [3:0] settings [10];
		int sent, d, np;
		bit paused;
		settings = '{4'd3, 4'd8, 4'd1, 4'd0, 4'd15, 4'd5, 4'd2, 4'd7, 4'd4, 4'd6};
		sent = 0;
		paused = 0;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		sample_valid <= 1'b0;
		sample_data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// partial point at batch end with eight dims: an empty merge
		send_sample(32'h7FFF_FFFF, 0, 1);
		write_dims(4'd1);
		// first point alone gives the forced unit variance
		send_sample(32'h8000_0000, 0, 1);
		// dimension outside those in use is dropped but still ends the batch
		send_sample(32'h1234_5678, 5, 1);
		send_sample(32'h7FFF_FFFF, 0, 0);
		send_sample(32'h8000_0000, 0, 1);
		write_dims(4'd0);
		send_sample(32'h0000_0000, 0, 0);
		send_sample(32'hFFFF_FFFF, 0, 1);
		write_dims(4'd15);
		for (int k = 0; k < 8; k++) send_sample(k[0] ? 32'h8000_0000 : 32'h7FFF_FFFF, k, k == 7);
		for (int k = 0; k < 8; k++) send_sample(32'h0001_0000, k, k == 7);
		write_dims(4'd8);

		// random phases, one per dimension setting
		for (int ph = 0; ph < 10; ph++) begin
			int phase_items;
			write_dims(settings[ph]);
			no_idle = (ph == 3 || ph == 7);
			d = board.active_dims();
			phase_items = 0;
			while (phase_items < 40) begin
				if (ph == 5 && phase_items > 20 && !paused) begin
					paused = 1;
					drain();
				end
				if ($urandom_range(0, 9) < 8) begin
					np = $urandom_range(0, 3);
					if (np == 0) begin
						send_sample(pick_value(), $urandom_range(0, 7), 1);
						phase_items++;
					end
					for (int p = 0; p < np; p++)
						for (int k = 0; k < d; k++) begin
							send_sample(pick_value(), k, (p == np - 1) && (k == d - 1));
							phase_items++;
						end
				end else begin
					send_sample(pick_value(), $urandom_range(0, 7), $urandom_range(0, 5) == 0);
					phase_items++;
				end
			end
			sent += phase_items;
		end
		drain();
		if (board.mismatches == 0 && board.expected_q.size() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/brv_pkg.sv
rtl/brv_div.sv
rtl/brv_dp.sv
rtl/brv_ctrl.sv
rtl/batch_running_variance_unit.sv
tb/testbench.sv
